### rtl/core/tspf_pkg.sv
// Shared types and constants for the transport stream filter with continuity check.
// No dependencies; every other file except tspf_ram uses this package.
package tspf_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int PID_ENTRIES  = 8192;
    localparam int PID_AW       = $clog2(PID_ENTRIES);
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int CC_W         = 4;
    localparam int ENTRY_W      = CC_W + 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]        SYNC_BYTE = 8'h47;
    localparam logic [PID_AW-1:0] NULL_PID  = {PID_AW{1'b1}};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DISCONT   = 3'd1,
        ST_TEI_DROP  = 3'd2,
        ST_NULL_DROP = 3'd3,
        ST_SHORT     = 3'd4,
        ST_SYNC_LOST = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EV_SYNC_LOST,
        EV_SHORT,
        EV_FINISH
    } evt_kind_t;

    // Latched header: error flag, PID, payload flag, continuity counter
    typedef struct packed {
        logic              tei;
        logic [PID_AW-1:0] pid;
        logic              pay;
        logic [CC_W-1:0]   cc;
    } hdr_t;

    typedef struct packed {
        logic      valid;
        evt_kind_t kind;
        hdr_t      hdr;
    } pkt_evt_t;

    typedef struct packed {
        logic clearing;
        logic pending;
    } chk_status_t;

    typedef struct packed {
        status_t           status;
        logic [PID_AW-1:0] pid;
        logic [CC_W-1:0]   rx;
        logic [CC_W-1:0]   ex;
    } result_t;

endpackage

### rtl/core/tspf_if.sv
// Valid/ready channel interfaces for the stream input and the result output.
// Depends on tspf_pkg for field widths.
interface tspf_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       datagram_end;

    modport source (output valid, output stream_byte, output datagram_end, input ready);
    modport sink   (input valid, input stream_byte, input datagram_end, output ready);
endinterface

interface tspf_result_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [tspf_pkg::PID_AW-1:0] packet_pid;
    logic [tspf_pkg::CC_W-1:0]   received_counter;
    logic [tspf_pkg::CC_W-1:0]   expected_counter;

    modport source (output valid, output status, output packet_pid,
                    output received_counter, output expected_counter, input ready);
    modport sink   (input valid, input status, input packet_pid,
                    input received_counter, input expected_counter, output ready);
endinterface

### rtl/core/tspf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tspf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tspf_parse.sv
// Byte-level packet framer: sync hunt, header latch, packet end and short packet detection.
// Depends on tspf_pkg.
module tspf_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         stream_byte,
    input  logic               datagram_end,
    output tspf_pkg::pkt_evt_t evt
);
    import tspf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             inside_reg, inside_next;
    logic             missing_reg, missing_next;
    hdr_t             hdr_reg, hdr_next;
    logic             evt_valid;
    evt_kind_t        evt_kind;

    always_comb
    begin
        pos_next     = pos_reg;
        inside_next  = inside_reg;
        missing_next = missing_reg;
        hdr_next     = hdr_reg;
        evt_valid    = 1'b0;
        evt_kind     = EV_SYNC_LOST;

        if (!inside_reg)
        begin
            if (stream_byte != SYNC_BYTE)
            begin
                // report once per run of non-sync bytes
                if (!missing_reg)
                begin
                    evt_valid = 1'b1;
                    evt_kind  = EV_SYNC_LOST;
                end
                missing_next = 1'b1;
            end
            else
            begin
                missing_next = 1'b0;
                inside_next  = 1'b1;
                pos_next     = POS_W'(1);
                hdr_next     = '0;
            end
        end
        else
        begin
            case (pos_reg)
                POS_W'(1):
                begin
                    hdr_next.tei                 = stream_byte[7];
                    hdr_next.pid[PID_AW-1:8]     = stream_byte[PID_AW-9:0];
                    hdr_next.pid[7:0]            = '0;
                end
                POS_W'(2):
                begin
                    hdr_next.pid[7:0] = stream_byte;
                end
                POS_W'(3):
                begin
                    hdr_next.pay = stream_byte[4];
                    hdr_next.cc  = stream_byte[CC_W-1:0];
                end
                default:
                begin
                end
            endcase
            if (pos_reg >= POS_W'(PACKET_BYTES - 1))
            begin
                evt_valid   = 1'b1;
                evt_kind    = EV_FINISH;
                inside_next = 1'b0;
                pos_next    = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        // datagram end abandons an open packet and rearms the sync loss report
        if (datagram_end)
        begin
            if (inside_next)
            begin
                evt_valid   = 1'b1;
                evt_kind    = EV_SHORT;
                inside_next = 1'b0;
                pos_next    = '0;
            end
            missing_next = 1'b0;
        end
    end

    assign evt.valid = accept && evt_valid;
    assign evt.kind  = evt_kind;
    assign evt.hdr   = hdr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            inside_reg  <= 1'b0;
            missing_reg <= 1'b0;
            hdr_reg     <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            inside_reg  <= inside_next;
            missing_reg <= missing_next;
            hdr_reg     <= hdr_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg |-> (pos_reg >= POS_W'(1)) && (pos_reg <= POS_W'(PACKET_BYTES - 1)))
        else $error("byte position out of packet range");
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_reg |-> pos_reg == '0)
        else $error("byte position nonzero while hunting");
`endif

endmodule

### rtl/core/tspf_cc_check.sv
// Continuity counter table: clearing pass, table read at packet end, check and write back.
// Depends on tspf_pkg and tspf_ram.
module tspf_cc_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tspf_pkg::pkt_evt_t    evt,
    output tspf_pkg::chk_status_t stat,
    output logic                  push,
    output tspf_pkg::result_t     res
);
    import tspf_pkg::*;

    logic              clearing_reg;
    logic [PID_AW-1:0] clr_addr_reg;
    logic              s1_valid_reg;
    pkt_evt_t          s1_evt_reg;

    logic               rd_en;
    logic               tbl_we;
    logic               chk_we;
    logic [PID_AW-1:0]  tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [CC_W-1:0]    expect_cc;
    result_t            res_c;

    // read the entry in the cycle the last byte is accepted
    assign rd_en = evt.valid && (evt.kind == EV_FINISH);

    always_comb
    begin
        res_c     = '0;
        res_c.status = ST_OK;
        chk_we    = 1'b0;
        expect_cc = s1_evt_reg.hdr.cc;
        if (tbl_rdata[CC_W])
        begin
            expect_cc = tbl_rdata[CC_W-1:0] + {{(CC_W-1){1'b0}}, s1_evt_reg.hdr.pay};
        end
        case (s1_evt_reg.kind)
            EV_SYNC_LOST:
            begin
                res_c.status = ST_SYNC_LOST;
            end
            EV_SHORT:
            begin
                res_c.status = ST_SHORT;
            end
            EV_FINISH:
            begin
                res_c.pid = s1_evt_reg.hdr.pid;
                res_c.rx  = s1_evt_reg.hdr.cc;
                if (s1_evt_reg.hdr.tei)
                begin
                    res_c.status = ST_TEI_DROP;
                end
                else if (s1_evt_reg.hdr.pid == NULL_PID)
                begin
                    res_c.status = ST_NULL_DROP;
                end
                else
                begin
                    res_c.ex     = expect_cc;
                    res_c.status = (expect_cc == s1_evt_reg.hdr.cc) ? ST_OK : ST_DISCONT;
                    chk_we       = s1_valid_reg;
                end
            end
            default:
            begin
                res_c.status = ST_SYNC_LOST;
            end
        endcase
    end

    assign tbl_we    = clearing_reg || chk_we;
    assign tbl_waddr = clearing_reg ? clr_addr_reg : s1_evt_reg.hdr.pid;
    assign tbl_wdata = clearing_reg ? '0 : {1'b1, s1_evt_reg.hdr.cc};

    tspf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PID_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (rd_en),
        .raddr (evt.hdr.pid),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + PID_AW'(1);
                if (clr_addr_reg == PID_AW'(PID_ENTRIES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s1_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid)
        begin
            s1_evt_reg <= evt;
        end
    end

    assign push          = s1_valid_reg;
    assign res           = res_c;
    assign stat.clearing = clearing_reg;
    assign stat.pending  = s1_valid_reg;

`ifndef SYNTHESIS
    a_no_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !rd_en)
        else $error("table read during clearing pass");
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && chk_we))
        else $error("table read and write back in the same cycle");
    a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        chk_we |-> $past(rd_en))
        else $error("write back without a table read one cycle earlier");
`endif

endmodule

### rtl/core/tspf_out_fifo.sv
// Result queue: small register FIFO that drives the result channel.
// Depends on tspf_pkg and tspf_if.
module tspf_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tspf_pkg::result_t          din,
    output logic [tspf_pkg::FIFO_LW-1:0] level,
    tspf_result_if.source              result
);
    import tspf_pkg::*;

    result_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_LW-1:0] level_reg;
    logic               pop;
    result_t            head;

    assign head  = fifo_mem_reg[rd_ptr_reg];
    assign pop   = result.valid && result.ready;
    assign level = level_reg;

    assign result.valid            = level_reg != '0;
    assign result.status           = head.status;
    assign result.packet_pid       = head.pid;
    assign result.received_counter = head.rx;
    assign result.expected_counter = head.ex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + FIFO_LW'(1);
                2'b01:   level_reg <= level_reg - FIFO_LW'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> level_reg < FIFO_LW'(FIFO_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

### rtl/core/ts_packet_filter_cc_check_unit.sv
// Transport stream filter with per-PID continuity counter check: one byte per clock
// while stream.ready is high; each result is registered in the check stage and then in
// the result queue. The table is read when the last byte of a packet is accepted and
// written back in the next cycle through a single 8192 x 5 RAM. After reset a clearing
// pass writes every entry, one per cycle, with stream.ready low. Ready also drops while
// the four-entry result queue cannot take another item because the sink stalls.
// Depends on tspf_pkg, tspf_if, tspf_parse, tspf_cc_check, tspf_out_fifo.
module ts_packet_filter_cc_check_unit (
    input  logic           clk,
    input  logic           rst_n,
    tspf_stream_if.sink    stream,
    tspf_result_if.source  result
);
    import tspf_pkg::*;

    logic               in_ready;
    logic               accept;
    pkt_evt_t           evt;
    chk_status_t        stat;
    logic               push;
    result_t            res;
    logic [FIFO_LW-1:0] level;
    logic [FIFO_LW:0]   committed;

    // queue slots taken or promised to the item in the check stage
    assign committed = {1'b0, level} + {{FIFO_LW{1'b0}}, stat.pending};
    assign in_ready  = !stat.clearing && (committed <= (FIFO_LW + 1)'(FIFO_DEPTH - 1));
    assign stream.ready = in_ready;
    assign accept    = stream.valid && in_ready;

    tspf_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .stream_byte  (stream.stream_byte),
        .datagram_end (stream.datagram_end),
        .evt          (evt)
    );

    tspf_cc_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .stat  (stat),
        .push  (push),
        .res   (res)
    );

    tspf_out_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (res),
        .level  (level),
        .result (result)
    );

endmodule
